/* sv/afs_pkg.sv */
package afs_pkg;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_WRITE_ENABLE = 2'd1,
        OP_WRITE_CTRL  = 2'd2,
        OP_READ_STATUS = 2'd3
    } op_t;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [2:0] STEPS_FOUR = 3'd4;
    localparam logic [2:0] STEPS_FIVE = 3'd5;
    localparam logic [2:0] STEP_LAST_QUARTER = 3'd3;

    // control byte bits
    localparam int unsigned CTRL_MODE_BIT    = 7;
    localparam int unsigned CTRL_INHIBIT_BIT = 6;
    // enable byte bit of the sample channel
    localparam int unsigned EN_DMC_BIT = 4;

    // result of one transaction
    typedef struct packed {
        logic       dmc_irq_ack;
        logic [4:0] channel_enables;
        logic [7:0] read_data;
        logic       irq_clear;
        logic       irq_raise;
        logic       half_frame;
        logic       quarter_frame;
    } result_t;

endpackage

/* sv/audio_frame_sequencer.sv */
// Frame sequencer and status register of a sound chip. Every input transaction is
// a tick (tuser = 0), an enable write (1), a control write (2) or a status read (3),
// and yields exactly one result transaction carrying the strobes, interrupt requests,
// status byte and latched channel enables. The block is a two-register pipeline:
// one transaction per clock is accepted while the output is not stalled; each accepted
// transaction passes from the input register into the result register, whose content is
// presented on the master side.
module audio_frame_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data, [11:8] channel_active, [12] dmc_bytes_left, [13] dmc_irq_pending
    input  logic [15:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] quarter_frame, [1] half_frame, [2] irq_raise, [3] irq_clear,
    // [11:4] read_data, [16:12] channel_enables, [17] dmc_irq_ack
    output logic [23:0] m_axis_tdata
);

    // input register
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [7:0]  data_reg;
    logic [3:0]  active_reg;
    logic        bytes_left_reg;
    logic        dmc_pend_reg;

    // result register
    logic                 out_valid_reg;
    afs_pkg::result_t     result_reg;
    afs_pkg::result_t     result_next;

    // sequencer state
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       five_step_reg;
    logic       five_step_next;
    logic       inhibit_reg;
    logic       inhibit_next;
    logic       frame_flag_reg;
    logic       frame_flag_next;
    logic [4:0] enable_reg;
    logic [4:0] enable_next;

    logic       advance;
    logic [2:0] wrap;
    logic [2:0] cur_step;
    logic [2:0] inc_step;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign wrap     = five_step_reg ? afs_pkg::STEPS_FIVE : afs_pkg::STEPS_FOUR;
    assign cur_step = (step_reg >= wrap) ? 3'd0 : step_reg;
    assign inc_step = cur_step + 3'd1;

    always_comb
    begin
        result_next     = '0;
        step_next       = step_reg;
        five_step_next  = five_step_reg;
        inhibit_next    = inhibit_reg;
        frame_flag_next = frame_flag_reg;
        enable_next     = enable_reg;

        unique case (afs_pkg::op_t'(op_reg))
            afs_pkg::OP_TICK:
            begin
                // step 4 of five-step mode is silent
                if (cur_step < afs_pkg::STEPS_FOUR)
                begin
                    result_next.quarter_frame = 1'b1;
                    result_next.half_frame    = cur_step[0];
                end
                if (!five_step_reg && cur_step == afs_pkg::STEP_LAST_QUARTER && !inhibit_reg)
                begin
                    frame_flag_next       = 1'b1;
                    result_next.irq_raise = 1'b1;
                end
                step_next = (inc_step >= wrap) ? 3'd0 : inc_step;
            end
            afs_pkg::OP_WRITE_ENABLE:
            begin
                enable_next             = data_reg[4:0];
                result_next.irq_clear   = !data_reg[afs_pkg::EN_DMC_BIT];
                result_next.dmc_irq_ack = 1'b1;
            end
            afs_pkg::OP_WRITE_CTRL:
            begin
                five_step_next = data_reg[afs_pkg::CTRL_MODE_BIT];
                inhibit_next   = data_reg[afs_pkg::CTRL_INHIBIT_BIT];
                if (data_reg[afs_pkg::CTRL_INHIBIT_BIT])
                begin
                    frame_flag_next       = 1'b0;
                    result_next.irq_clear = 1'b1;
                end
                if (data_reg == 8'd0)
                begin
                    frame_flag_next       = 1'b1;
                    result_next.irq_raise = 1'b1;
                end
                if (data_reg[afs_pkg::CTRL_MODE_BIT])
                begin
                    result_next.quarter_frame = 1'b1;
                    result_next.half_frame    = 1'b1;
                end
            end
            afs_pkg::OP_READ_STATUS:
            begin
                result_next.read_data = {dmc_pend_reg, frame_flag_reg, 1'b0,
                                         bytes_left_reg, active_reg};
                frame_flag_next       = 1'b0;
                result_next.irq_clear = 1'b1;
            end
            default:
            begin
                result_next = '0;
            end
        endcase

        result_next.channel_enables = enable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
            five_step_reg  <= 1'b0;
            inhibit_reg    <= 1'b0;
            frame_flag_reg <= 1'b0;
            enable_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // state moves only when a transaction passes into the result register
            if (advance && in_valid_reg)
            begin
                step_reg       <= step_next;
                five_step_reg  <= five_step_next;
                inhibit_reg    <= inhibit_next;
                frame_flag_reg <= frame_flag_next;
                enable_reg     <= enable_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg         <= s_axis_tuser;
            data_reg       <= s_axis_tdata[7:0];
            active_reg     <= s_axis_tdata[11:8];
            bytes_left_reg <= s_axis_tdata[12];
            dmc_pend_reg   <= s_axis_tdata[13];
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, result_reg};

endmodule

/* tb/testbench.sv */
module testbench;

    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SEGMENT_ITEMS  = 50;
    localparam int unsigned SEGMENTS       = 15;

    // Predicts each result from its transaction and checks the results in order.
    class frame_seq_scoreboard;
        logic [2:0] seq_step;
        logic       five_step;
        logic       inhibit;
        logic       frame_flag;
        logic [4:0] enables;
        afs_pkg::result_t pending_results[$];
        int unsigned mismatches;

        function new();
            seq_step   = '0;
            five_step  = 1'b0;
            inhibit    = 1'b0;
            frame_flag = 1'b0;
            enables    = '0;
            mismatches = 0;
        endfunction

        function afs_pkg::result_t predict_result(afs_pkg::op_t op, logic [7:0] data,
                                                  logic [3:0] active, logic bytes_left,
                                                  logic irq_pend);
            afs_pkg::result_t res;
            logic [2:0] wrap;
            logic [2:0] cur;
            res = '0;
            case (op)
                afs_pkg::OP_TICK:
                begin
                    wrap = five_step ? afs_pkg::STEPS_FIVE : afs_pkg::STEPS_FOUR;
                    cur  = (seq_step >= wrap) ? 3'd0 : seq_step;
                    if (cur <= afs_pkg::STEP_LAST_QUARTER)
                    begin
                        res.quarter_frame = 1'b1;
                        res.half_frame    = cur[0];
                    end
                    if (!five_step && cur == afs_pkg::STEP_LAST_QUARTER && !inhibit)
                    begin
                        frame_flag    = 1'b1;
                        res.irq_raise = 1'b1;
                    end
                    cur      = cur + 3'd1;
                    seq_step = (cur >= wrap) ? 3'd0 : cur;
                end
                afs_pkg::OP_WRITE_ENABLE:
                begin
                    enables         = data[4:0];
                    res.irq_clear   = !data[afs_pkg::EN_DMC_BIT];
                    res.dmc_irq_ack = 1'b1;
                end
                afs_pkg::OP_WRITE_CTRL:
                begin
                    five_step = data[afs_pkg::CTRL_MODE_BIT];
                    inhibit   = data[afs_pkg::CTRL_INHIBIT_BIT];
                    if (inhibit)
                    begin
                        res.irq_clear = 1'b1;
                        frame_flag    = 1'b0;
                    end
                    if (data == 8'h00)
                    begin
                        frame_flag    = 1'b1;
                        res.irq_raise = 1'b1;
                    end
                    if (five_step)
                    begin
                        res.quarter_frame = 1'b1;
                        res.half_frame    = 1'b1;
                    end
                end
                default:
                begin
                    res.read_data = {irq_pend, frame_flag, 1'b0, bytes_left, active};
                    frame_flag    = 1'b0;
                    res.irq_clear = 1'b1;
                end
            endcase
            res.channel_enables = enables;
            return res;
        endfunction

        function void note_transaction(afs_pkg::op_t op, logic [7:0] data, logic [3:0] active,
                                       logic bytes_left, logic irq_pend);
            pending_results.push_back(predict_result(op, data, active, bytes_left, irq_pend));
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [afs_pkg::OUT_TDATA_W-1:0] word);
            afs_pkg::result_t want;
            afs_pkg::result_t got;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, word);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            got  = afs_pkg::result_t'(word[$bits(afs_pkg::result_t)-1:0]);
            check_field("quarter_frame", want.quarter_frame, got.quarter_frame);
            check_field("half_frame", want.half_frame, got.half_frame);
            check_field("irq_raise", want.irq_raise, got.irq_raise);
            check_field("irq_clear", want.irq_clear, got.irq_clear);
            check_field("read_data", want.read_data, got.read_data);
            check_field("channel_enables", want.channel_enables, got.channel_enables);
            check_field("dmc_irq_ack", want.dmc_irq_ack, got.dmc_irq_ack);
            check_field("tdata padding", 0,
                        word[afs_pkg::OUT_TDATA_W-1:$bits(afs_pkg::result_t)]);
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [afs_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [afs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    frame_seq_scoreboard sb;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    bit          hold_req   = 1'b0;
    int unsigned idle_cycles = 0;

    audio_frame_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_item(afs_pkg::op_t op, logic [7:0] data, logic [3:0] active,
                             logic bytes_left, logic irq_pend);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, irq_pend, bytes_left, active, data};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // status side inputs are random on every transaction; only op and data are steered
    task automatic send_op(afs_pkg::op_t op, logic [7:0] data);
        send_item(op, data, 4'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_random_item();
        int unsigned pick;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        if (pick < 55)
            send_op(afs_pkg::OP_TICK, data);
        else if (pick < 65)
            send_op(afs_pkg::OP_WRITE_ENABLE, data);
        else if (pick < 80)
        begin
            // bias control bytes toward the mode/inhibit corners and toward zero
            case ($urandom_range(0, 3))
                0: data = 8'h00;
                1: data = {data[7:6], 6'd0};
                default: ;
            endcase
            send_op(afs_pkg::OP_WRITE_CTRL, data);
        end
        else
            send_op(afs_pkg::OP_READ_STATUS, data);
    endtask

    // receiver: random stall per transaction, plus one long hold-off on request
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = rx_gaps_on ? $urandom_range(0, 3) : 0;
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_transaction(afs_pkg::op_t'(s_axis_tuser), s_axis_tdata[7:0],
                                s_axis_tdata[11:8], s_axis_tdata[12], s_axis_tdata[13]);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reads at both extremes of the status inputs
        send_item(afs_pkg::OP_READ_STATUS, 8'h00, 4'h0, 1'b0, 1'b0);
        send_item(afs_pkg::OP_READ_STATUS, 8'hFF, 4'hF, 1'b1, 1'b1);
        // full four-step sequence sets the frame flag, read clears it
        repeat (4) send_op(afs_pkg::OP_TICK, 8'($urandom));
        send_op(afs_pkg::OP_READ_STATUS, 8'h00);
        // zero control byte forces the flag
        send_op(afs_pkg::OP_WRITE_CTRL, 8'h00);
        send_op(afs_pkg::OP_READ_STATUS, 8'h00);
        // inhibited four-step sequence: no interrupt
        send_op(afs_pkg::OP_WRITE_CTRL, 8'h40);
        repeat (4) send_op(afs_pkg::OP_TICK, 8'hFF);
        // five-step: strobes on the write, counter left at step 4
        send_op(afs_pkg::OP_WRITE_CTRL, 8'h80);
        repeat (4) send_op(afs_pkg::OP_TICK, 8'($urandom));
        // back to four-step with the counter out of range
        send_op(afs_pkg::OP_WRITE_CTRL, 8'h00);
        send_op(afs_pkg::OP_TICK, 8'h00);
        // enable writes with and without the sample channel
        send_op(afs_pkg::OP_WRITE_ENABLE, 8'h1F);
        send_op(afs_pkg::OP_WRITE_ENABLE, 8'h0F);
        send_op(afs_pkg::OP_WRITE_ENABLE, 8'hE0);
        send_op(afs_pkg::OP_WRITE_CTRL, 8'hFF);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if (seg == 3)
            begin
                // receiver blocks while the sender keeps pushing
                tx_gaps_on = 1'b0;
                hold_req   = 1'b1;
            end
            repeat (SEGMENT_ITEMS) send_random_item();
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
